FILE: rtl/gpke_pkg.sv
// ----------------------------------------------------------------------------
// gpke_pkg
// Shared types, constants and the key derivation for the gamepad packet
// to key event converter.
// ----------------------------------------------------------------------------
package gpke_pkg;

    localparam int PAYLOAD_LENGTH = 6;
    localparam int KEY_COUNT      = 13;
    localparam int KEY_IDX_W      = 4;

    // Payload byte positions (count value when the byte arrives)
    localparam logic [2:0] POS_LX     = 3'd0;
    localparam logic [2:0] POS_LY     = 3'd1;
    localparam logic [2:0] POS_RX     = 3'd2;
    localparam logic [2:0] POS_BTN_LO = 3'd4;
    localparam logic [2:0] POS_LAST   = 3'(PAYLOAD_LENGTH - 1);

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_STICK_LOW   = 2'd2;
    localparam logic [1:0] CFG_STICK_HIGH  = 2'd3;

    localparam logic [7:0] RST_SYNC_FIRST  = 8'h55;
    localparam logic [7:0] RST_SYNC_SECOND = 8'hAA;
    localparam logic [7:0] RST_STICK_LOW   = 8'd100;
    localparam logic [7:0] RST_STICK_HIGH  = 8'd200;
    localparam logic [7:0] RST_STICK_POS   = 8'd127;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_SYNC2   = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] stick_low;
        logic [7:0] stick_high;
    } cfg_t;

    // Packet evaluation handed from the parser to the event emitter
    typedef struct packed {
        logic                 valid;
        logic [KEY_COUNT-1:0] mask;
        logic [KEY_COUNT-1:0] keys;
    } key_load_t;

    // Map sticks and buttons onto the thirteen virtual keys
    function automatic logic [KEY_COUNT-1:0] derive_keys(
        input logic [7:0]  lx,
        input logic [7:0]  ly,
        input logic [7:0]  rx,
        input logic [15:0] b,
        input logic [7:0]  lo,
        input logic [7:0]  hi
    );
        logic                 rx_low;
        logic                 rx_high;
        logic                 ly_low;
        logic                 ly_high;
        logic                 lx_low;
        logic                 lx_high;
        logic [KEY_COUNT-1:0] k;
        rx_low   = rx < lo;
        rx_high  = !rx_low && (rx > hi);
        ly_high  = ly > hi;
        ly_low   = !ly_high && (ly < lo);
        lx_low   = lx < lo;
        lx_high  = !lx_low && (lx > hi);
        k[0]     = b[5] | rx_low;
        k[1]     = b[6] | rx_high;
        k[2]     = b[4] | ly_high;
        k[3]     = b[7] | ly_low;
        k[4]     = b[11];
        k[5]     = b[3];
        k[6]     = b[2];
        k[7]     = lx_low;
        k[8]     = lx_high;
        k[9]     = b[1];
        k[10]    = b[9];
        k[11]    = b[10];
        k[12]    = b[8];
        return k;
    endfunction

endpackage

FILE: rtl/gpke_parser.sv
// ----------------------------------------------------------------------------
// gpke_parser
// Sync hunt, payload capture and old/new key comparison per packet.
// ----------------------------------------------------------------------------
module gpke_parser
    import gpke_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       emit_busy,
    output key_load_t  load
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;

    // Payload holding registers; right Y is dropped as it drives no key
    logic [7:0]  lx_reg;
    logic [7:0]  ly_reg;
    logic [7:0]  rx_reg;
    logic [7:0]  btn_lo_reg;

    logic [7:0]  prev_lx_reg;
    logic [7:0]  prev_ly_reg;
    logic [7:0]  prev_rx_reg;
    logic [15:0] prev_btn_reg;

    logic        accept;
    logic        final_beat;
    logic [15:0] btn;
    logic [KEY_COUNT-1:0] new_keys;
    logic [KEY_COUNT-1:0] old_keys;

    assign final_beat = (phase_reg == PH_PAYLOAD) && (count_reg == POS_LAST);
    // Hold off a packet-closing byte until the previous burst has drained
    assign in_ready   = !(final_beat && emit_busy);
    assign accept     = in_valid && in_ready;

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_SYNC2:
                begin
                    phase_next = (in_byte == cfg.sync_second) ? PH_PAYLOAD : PH_HUNT;
                    count_next = '0;
                end
                PH_PAYLOAD:
                begin
                    if (count_reg == POS_LAST)
                    begin
                        phase_next = PH_HUNT;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_reg + 3'd1;
                    end
                end
                default:
                begin
                    phase_next = (in_byte == cfg.sync_first) ? PH_SYNC2 : PH_HUNT;
                    count_next = '0;
                end
            endcase
        end
    end

    // Outputs: evaluate the packet on its final byte
    always_comb
    begin
        btn      = {in_byte, btn_lo_reg};
        new_keys = derive_keys(lx_reg, ly_reg, rx_reg, btn, cfg.stick_low, cfg.stick_high);
        old_keys = derive_keys(prev_lx_reg, prev_ly_reg, prev_rx_reg, prev_btn_reg,
                               cfg.stick_low, cfg.stick_high);
        load.valid = accept && final_beat;
        load.mask  = new_keys ^ old_keys;
        load.keys  = new_keys;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (phase_reg == PH_PAYLOAD))
        begin
            case (count_reg)
                POS_LX:     lx_reg     <= in_byte;
                POS_LY:     ly_reg     <= in_byte;
                POS_RX:     rx_reg     <= in_byte;
                POS_BTN_LO: btn_lo_reg <= in_byte;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_lx_reg  <= RST_STICK_POS;
            prev_ly_reg  <= RST_STICK_POS;
            prev_rx_reg  <= RST_STICK_POS;
            prev_btn_reg <= '0;
        end
        else if (load.valid)
        begin
            prev_lx_reg  <= lx_reg;
            prev_ly_reg  <= ly_reg;
            prev_rx_reg  <= rx_reg;
            prev_btn_reg <= btn;
        end
    end

endmodule

FILE: rtl/gpke_emitter.sv
// ----------------------------------------------------------------------------
// gpke_emitter
// Drains the changed-key mask lowest key first, one event beat per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module gpke_emitter
    import gpke_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  key_load_t            load,
    output logic                 busy,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KEY_IDX_W-1:0] key_index,
    output logic                 pressed,
    output logic                 last_event
);

    logic [KEY_COUNT-1:0] pending_reg;
    logic [KEY_COUNT-1:0] pending_next;
    logic [KEY_COUNT-1:0] keys_reg;
    logic                 valid_reg;
    logic [KEY_IDX_W-1:0] index_reg;
    logic                 pressed_reg;
    logic                 last_reg;

    logic [KEY_COUNT-1:0] low_bit;
    logic [KEY_COUNT-1:0] rest;
    logic [KEY_IDX_W-1:0] low_idx;
    logic                 advance;

    assign busy    = |pending_reg;
    assign advance = busy && (!valid_reg || out_ready);
    assign low_bit = pending_reg & (~pending_reg + KEY_COUNT'(1));
    assign rest    = pending_reg & ~low_bit;

    always_comb
    begin
        low_idx = '0;
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            if (low_bit[i])
            begin
                low_idx = low_idx | KEY_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        pending_next = pending_reg;
        if (load.valid)
        begin
            pending_next = load.mask;
        end
        else if (advance)
        begin
            pending_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (advance)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.valid)
        begin
            keys_reg <= load.keys;
        end
        if (advance)
        begin
            index_reg   <= low_idx;
            pressed_reg <= |(low_bit & keys_reg);
            last_reg    <= ~|rest;
        end
    end

    assign out_valid  = valid_reg;
    assign key_index  = index_reg;
    assign pressed    = pressed_reg;
    assign last_event = last_reg;

    // A new packet only lands on an empty mask
    a_load_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
        load.valid |-> (pending_reg == '0))
        else $error("packet loaded while events still pending");

    // Event index stays within the key set
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (index_reg < KEY_IDX_W'(KEY_COUNT)))
        else $error("event key index out of range");

    // A beat not marked last always has a follower queued
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !last_reg) |-> (pending_reg != '0))
        else $error("non-final event with nothing pending");

    // Pending work with a free output slot shows up next cycle
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> valid_reg)
        else $error("pending event failed to reach the output register");

endmodule

FILE: rtl/gamepad_packet_to_key_events.sv
// ----------------------------------------------------------------------------
// gamepad_packet_to_key_events
// Turns a gamepad serial packet stream into key press/release events.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one received serial byte per beat. The parser hunts
//   for the two sync bytes, then collects six payload bytes (left X, left Y,
//   right X, right Y, buttons low, buttons high).
//   Master stream m_*: one event per beat, key index and press flag in
//   m_tdata, m_tlast set on the final event of a packet. A packet whose
//   keys match the previous packet produces no beats.
//   cfg_*: register writes (sync bytes, stick thresholds); write only while
//   no packet events are outstanding.
// Timing and throughput:
//   Bytes are taken back to back. The byte that closes a packet loads the
//   changed-key mask register; the first event passes through the single
//   output register, then one event per cycle while m_tready is high, up to
//   13 per packet. A closing byte that arrives while an earlier burst is
//   still draining is held (s_tready low) until that burst has left the mask.
// Reset: parser back to sync hunt, no events pending, previous sticks at
//   mid-scale (127) and previous buttons clear, registers to defaults.
// Stall: m_tready low holds the current event; only a closing byte is held.
// ----------------------------------------------------------------------------
module gamepad_packet_to_key_events
    import gpke_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [3:0] key_index, [4] pressed, [7:5] zero
    output logic       m_tlast,     // last_event
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_t                 cfg_reg;
    key_load_t            load;
    logic                 emit_busy;
    logic [KEY_IDX_W-1:0] key_index;
    logic                 pressed;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first  <= RST_SYNC_FIRST;
            cfg_reg.sync_second <= RST_SYNC_SECOND;
            cfg_reg.stick_low   <= RST_STICK_LOW;
            cfg_reg.stick_high  <= RST_STICK_HIGH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYNC_FIRST:  cfg_reg.sync_first  <= cfg_data;
                CFG_SYNC_SECOND: cfg_reg.sync_second <= cfg_data;
                CFG_STICK_LOW:   cfg_reg.stick_low   <= cfg_data;
                CFG_STICK_HIGH:  cfg_reg.stick_high  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Framing and packet evaluation
    gpke_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .emit_busy (emit_busy),
        .load      (load)
    );

    // Event serializer with output register
    gpke_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .busy       (emit_busy),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .key_index  (key_index),
        .pressed    (pressed),
        .last_event (m_tlast)
    );

    assign m_tdata = {3'b000, pressed, key_index};

endmodule

FILE: bench/gpke_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpke_checker
// Watches the byte, event and register channels of the gamepad key event
// converter. It keeps its own copy of the parser and key state, predicts
// the events of every packet and compares each event beat with the oldest
// prediction.
// ----------------------------------------------------------------------------
module gpke_checker
    import gpke_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tlast,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         mismatch_count,
    output int         pending_events,
    output int         event_count,
    output int         packet_count
);

    typedef struct packed {
        logic [3:0] key;
        logic       pressed;
        logic       last;
    } key_event_t;

    key_event_t     key_event_q[$];
    cfg_t           cfg;
    phase_t         phase;
    logic [2:0]     payload_cnt;
    logic [7:0]     payload_buf [PAYLOAD_LENGTH-1];
    logic [7:0]     last_lx;
    logic [7:0]     last_ly;
    logic [7:0]     last_rx;
    logic [15:0]    last_buttons;
    int             errors = 0;
    int             pending_n = 0;
    int             events_seen = 0;
    int             packets_done = 0;

    assign mismatch_count = errors;
    assign pending_events = pending_n;
    assign event_count    = events_seen;
    assign packet_count   = packets_done;

    // Key map from one set of stick and button values, under the current
    // thresholds; the guards decide the winner when low is above high.
    function automatic logic [KEY_COUNT-1:0] keys_from_pad(
        input logic [7:0]  lx,
        input logic [7:0]  ly,
        input logic [7:0]  rx,
        input logic [15:0] btn
    );
        logic rx_lo;
        logic rx_hi;
        logic ly_lo;
        logic ly_hi;
        logic lx_lo;
        logic lx_hi;
        rx_lo = rx < cfg.stick_low;
        rx_hi = !rx_lo && (rx > cfg.stick_high);
        ly_hi = ly > cfg.stick_high;
        ly_lo = !ly_hi && (ly < cfg.stick_low);
        lx_lo = lx < cfg.stick_low;
        lx_hi = !lx_lo && (lx > cfg.stick_high);
        return {btn[8], btn[10], btn[9], btn[1], lx_hi, lx_lo, btn[2], btn[3],
                btn[11], btn[7] | ly_lo, btn[4] | ly_hi, btn[6] | rx_hi,
                btn[5] | rx_lo};
    endfunction

    // Advance the parser by one received byte; queue the events of a
    // completed packet in key order.
    task automatic apply_rx_byte(input logic [7:0] b);
        logic [KEY_COUNT-1:0] old_k;
        logic [KEY_COUNT-1:0] new_k;
        logic [KEY_COUNT-1:0] changed;
        logic [15:0]          btn;
        key_event_t           ev;
        case (phase)
            PH_SYNC2:
            begin
                // a wrong second byte is not retried as a first sync byte
                phase       = (b == cfg.sync_second) ? PH_PAYLOAD : PH_HUNT;
                payload_cnt = '0;
            end
            PH_PAYLOAD:
            begin
                if (payload_cnt < POS_LAST)
                begin
                    payload_buf[payload_cnt] = b;
                    payload_cnt              = payload_cnt + 3'd1;
                end
                else
                begin
                    btn     = {b, payload_buf[POS_BTN_LO]};
                    old_k   = keys_from_pad(last_lx, last_ly, last_rx, last_buttons);
                    new_k   = keys_from_pad(payload_buf[POS_LX], payload_buf[POS_LY],
                                            payload_buf[POS_RX], btn);
                    changed = old_k ^ new_k;
                    for (int k = 0; k < KEY_COUNT; k++)
                    begin
                        if (changed[k])
                        begin
                            ev.key     = 4'(k);
                            ev.pressed = new_k[k];
                            ev.last    = ((changed >> (k + 1)) == '0);
                            key_event_q.push_back(ev);
                        end
                    end
                    last_lx      = payload_buf[POS_LX];
                    last_ly      = payload_buf[POS_LY];
                    last_rx      = payload_buf[POS_RX];
                    last_buttons = btn;
                    phase        = PH_HUNT;
                    payload_cnt  = '0;
                    packets_done++;
                end
            end
            default:
            begin
                phase       = (b == cfg.sync_first) ? PH_SYNC2 : PH_HUNT;
                payload_cnt = '0;
            end
        endcase
    endtask

    task automatic check_event(input logic [7:0] data, input logic last);
        key_event_t exp_ev;
        if (key_event_q.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected event: expected none, got key %0d pressed %0b last %0b",
                     $time, data[3:0], data[4], last);
        end
        else
        begin
            exp_ev = key_event_q.pop_front();
            events_seen++;
            if (data[3:0] !== exp_ev.key || data[4] !== exp_ev.pressed ||
                data[7:5] !== 3'd0 || last !== exp_ev.last)
            begin
                errors++;
                $display("%0t: event mismatch: expected key %0d pressed %0b last %0b pad 0,",
                         $time, exp_ev.key, exp_ev.pressed, exp_ev.last);
                $display("    got key %0d pressed %0b last %0b pad %0d",
                         data[3:0], data[4], last, data[7:5]);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.sync_first  = RST_SYNC_FIRST;
            cfg.sync_second = RST_SYNC_SECOND;
            cfg.stick_low   = RST_STICK_LOW;
            cfg.stick_high  = RST_STICK_HIGH;
            phase           = PH_HUNT;
            payload_cnt     = '0;
            last_lx         = RST_STICK_POS;
            last_ly         = RST_STICK_POS;
            last_rx         = RST_STICK_POS;
            last_buttons    = '0;
            key_event_q.delete();
            pending_n      <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_event(m_tdata, m_tlast);
            // a byte taken at the same edge as a write still sees the old value
            if (s_tvalid && s_tready)
                apply_rx_byte(s_tdata);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SYNC_FIRST:  cfg.sync_first  = cfg_data;
                    CFG_SYNC_SECOND: cfg.sync_second = cfg_data;
                    CFG_STICK_LOW:   cfg.stick_low   = cfg_data;
                    CFG_STICK_HIGH:  cfg.stick_high  = cfg_data;
                    default: ;
                endcase
            end
            pending_n <= key_event_q.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the gamepad packet to key event converter.
// Sends directed and random serial byte streams (good packets, broken sync
// pairs, cut-off packets and noise) under several register settings, with
// random gaps on the byte side and random stalls on the event side. The
// checker beside the block predicts and compares every event beat.
// ----------------------------------------------------------------------------
module tb_top
    import gpke_pkg::*;
();

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = CFG_SYNC_FIRST;
    logic [7:0] cfg_data  = 8'h00;

    int         mismatch_count;
    int         pending_events;
    int         event_count;
    int         packet_count;

    // Stimulus-side copy of the register settings, used to build packets
    logic [7:0] sync_a;
    logic [7:0] sync_b;
    logic [7:0] thr_lo;
    logic [7:0] thr_hi;
    logic [7:0] pad_bytes [PAYLOAD_LENGTH];
    bit         idle_on   = 1'b1;
    int         bytes_sent = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    gamepad_packet_to_key_events uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [7:0] rx_byte
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [3:0] key_index, [4] pressed, [7:5] zero
        .m_tlast   (m_tlast),     // last_event
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gpke_checker event_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_events (pending_events),
        .event_count    (event_count),
        .packet_count   (packet_count)
    );

    // Event side: stall about a third of the cycles, never during a
    // steady stretch.
    always @(posedge clk)
        m_tready <= !idle_on || ($urandom_range(99) >= 33);

    // Hold one byte on the stream until it is taken; insert random gaps
    // first. tvalid stays high between back-to-back beats.
    task automatic send_byte(input logic [7:0] value);
        if (idle_on)
        begin
            while ($urandom_range(99) < 33)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Send the current sync pair and the six payload bytes in pad_bytes
    task automatic send_packet();
        send_byte(sync_a);
        send_byte(sync_b);
        for (int i = 0; i < PAYLOAD_LENGTH; i++)
            send_byte(pad_bytes[i]);
    endtask

    // Drop tvalid, wait until every predicted event has left the block, then
    // allow for a packet still being evaluated that produces no events.
    task automatic wait_drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_events != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
    endtask

    // Raise the write strobe for one register; the caller lowers it after
    // the last write so the strobe is assigned once per step.
    task automatic put_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic write_config(input logic [7:0] s1, input logic [7:0] s2,
                                input logic [7:0] lo, input logic [7:0] hi);
        put_reg(CFG_SYNC_FIRST, s1);
        put_reg(CFG_SYNC_SECOND, s2);
        put_reg(CFG_STICK_LOW, lo);
        put_reg(CFG_STICK_HIGH, hi);
        cfg_we <= 1'b0;
        @(posedge clk);
        sync_a = s1;
        sync_b = s2;
        thr_lo = lo;
        thr_hi = hi;
    endtask

    // Bias stick values toward the threshold edges and the rails
    function automatic logic [7:0] pick_stick();
        case ($urandom_range(7))
            0: return thr_lo - 8'd1;
            1: return thr_lo;
            2: return thr_hi;
            3: return thr_hi + 8'd1;
            4: return 8'd0;
            5: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Random stream for one register setting: mostly good packets, the rest
    // wrong second sync bytes, cut-off packets and stray bytes.
    task automatic random_phase(input int n_bytes);
        int start;
        int sel;
        int pos;
        int bit_pos;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
        begin
            sel = $urandom_range(99);
            if (sel < 70)
            begin
                if ($urandom_range(3) == 0)
                begin
                    // repeat the last payload, either exactly (no events)
                    // or with one button bit flipped
                    if ($urandom_range(1) == 1)
                    begin
                        pos     = 4 + $urandom_range(1);
                        bit_pos = $urandom_range(7);
                        pad_bytes[pos][bit_pos] = ~pad_bytes[pos][bit_pos];
                    end
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                        pad_bytes[i] = pick_stick();
                    pad_bytes[4] = 8'($urandom_range(255));
                    pad_bytes[5] = 8'($urandom_range(255));
                end
                send_packet();
            end
            else if (sel < 80)
            begin
                send_byte(sync_a);
                send_byte(sync_b ^ 8'($urandom_range(1, 255)));
            end
            else if (sel < 88)
            begin
                // cut-off packet: the next packet's bytes fill its payload
                send_byte(sync_a);
                send_byte(sync_b);
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(255)));
            end
            else
            begin
                send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        sync_a = RST_SYNC_FIRST;
        sync_b = RST_SYNC_SECOND;
        thr_lo = RST_STICK_LOW;
        thr_hi = RST_STICK_HIGH;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset register values.
        // Two first sync bytes in a row: the second is a wrong second byte
        // and must not restart the pair, so the 0xAA after it is ignored.
        send_byte(8'h55);
        send_byte(8'h55);
        send_byte(8'hAA);
        // Sync values on the left stick, rails on the right stick, all buttons
        pad_bytes = '{8'h55, 8'hAA, 8'h00, 8'hFF, 8'hFF, 8'hFF};
        send_packet();
        // Same packet again: keys unchanged, no events
        send_packet();
        // Opposite rails, all buttons released
        pad_bytes = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00};
        send_packet();
        wait_drain();

        // Random stream, reset register values
        random_phase(60);
        wait_drain();

        // Minimum sync values paired with maximum; thresholds at the rails,
        // so no stick ever counts as deflected
        write_config(8'h00, 8'hFF, 8'd0, 8'd255);
        random_phase(60);
        wait_drain();

        // Low threshold above high, in a steady stretch with no gaps or
        // stalls on either side
        idle_on = 1'b0;
        write_config(8'hFF, 8'h00, 8'd255, 8'd0);
        random_phase(60);
        wait_drain();
        idle_on = 1'b1;

        // Equal sync bytes, equal thresholds at mid-scale
        write_config(8'h3C, 8'h3C, 8'd128, 8'd128);
        random_phase(60);
        wait_drain();

        // Random register values
        write_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)));
        random_phase(60);
        wait_drain();

        $display("Sent %0d serial bytes under five register settings: %0d packets completed,",
                 bytes_sent, packet_count);
        $display("%0d key events checked, %0d mismatches, %0d events never delivered.",
                 event_count, mismatch_count, pending_events);
        if (mismatch_count == 0 && pending_events == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("Run timed out at %0t", $time);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
